// ===== src/pid_controller_antiwindup_unit_macros.svh =====
// Assertion macros for the PID controller unit.
`ifndef PID_CONTROLLER_ANTIWINDUP_UNIT_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define PIDAW_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PIDAW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PIDAW_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PIDAW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/pidaw_pkg.sv =====
`default_nettype none

package pidaw_pkg;

    // Default widths
    localparam int FRAC_BITS_DEF    = 12;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed datapath widths
    localparam int INT_W   = 32;   // internal values
    localparam int CHUNK_W = 24;   // low operand chunk of a split multiply
    localparam int COEF_W  = 16;
    localparam int MUL_A_W = COEF_W + 1;
    localparam int CFG_W   = 16;
    localparam int LIMIT_W = 15;
    localparam int POLE_W  = 12;

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_GAIN_K   = 3'd0;
    localparam t_reg_idx REG_SP_WEIGHT = 3'd1;
    localparam t_reg_idx REG_OUT_LIMIT = 3'd2;
    localparam t_reg_idx REG_DERIV_POLE = 3'd3;
    localparam t_reg_idx REG_DERIV_GAIN = 3'd4;
    localparam t_reg_idx REG_INTEG_GAIN = 3'd5;
    localparam t_reg_idx REG_TRACK_GAIN = 3'd6;

    // Register reset values
    localparam logic [COEF_W-1:0]  RST_GAIN_K     = 16'd0;
    localparam logic [COEF_W-1:0]  RST_SP_WEIGHT  = 16'd4096;
    localparam logic [LIMIT_W-1:0] RST_OUT_LIMIT  = 15'd32767;
    localparam logic [POLE_W-1:0]  RST_DERIV_POLE = 12'd0;
    localparam logic [COEF_W-1:0]  RST_COEF_ZERO  = 16'd0;

    // Coefficient select
    typedef logic [2:0] t_csel;
    localparam t_csel C_K  = 3'd0;
    localparam t_csel C_B  = 3'd1;
    localparam t_csel C_AD = 3'd2;
    localparam t_csel C_BD = 3'd3;
    localparam t_csel C_BI = 3'd4;
    localparam t_csel C_AR = 3'd5;

    // Multiplier operand select
    typedef logic [2:0] t_xsel;
    localparam t_xsel X_NONE = 3'd0;
    localparam t_xsel X_REF  = 3'd1;
    localparam t_xsel X_DY   = 3'd2;
    localparam t_xsel X_EY   = 3'd3;
    localparam t_xsel X_ALO  = 3'd4;
    localparam t_xsel X_AHI  = 3'd5;
    localparam t_xsel X_DLO  = 3'd6;
    localparam t_xsel X_DHI  = 3'd7;

    // Accumulator operation
    typedef logic [3:0] t_aop;
    localparam t_aop A_NOP    = 4'd0;
    localparam t_aop A_LOAD   = 4'd1;
    localparam t_aop A_ADDH   = 4'd2;
    localparam t_aop A_SUBYF  = 4'd3;
    localparam t_aop A_ASRSUB = 4'd4;
    localparam t_aop A_ASRADD = 4'd5;
    localparam t_aop A_LOADX  = 4'd6;
    localparam t_aop A_ADDX   = 4'd7;
    localparam t_aop A_TRK    = 4'd8;

    // Register source for LOADX / ADDX
    typedef logic [1:0] t_src;
    localparam t_src S_P   = 2'd0;
    localparam t_src S_INT = 2'd1;
    localparam t_src S_D   = 2'd2;

    // Writeback
    typedef logic [2:0] t_wb;
    localparam t_wb W_NONE  = 3'd0;
    localparam t_wb W_P     = 3'd1;
    localparam t_wb W_D     = 3'd2;
    localparam t_wb W_V     = 3'd3;
    localparam t_wb W_CLAMP = 3'd4;
    localparam t_wb W_INT   = 3'd5;

    // Jump condition
    typedef logic [1:0] t_jmp;
    localparam t_jmp J_NONE    = 2'd0;
    localparam t_jmp J_NOTRACK = 2'd1;
    localparam t_jmp J_ALWAYS  = 2'd2;

    // Program counter
    localparam int UC_AW = 5;
    typedef logic [UC_AW-1:0] t_step;
    localparam t_step UC_NOTRACK = 5'd20;
    localparam t_step UC_INT_WB  = 5'd22;
    localparam t_step UC_LAST    = 5'd22;

    typedef struct packed {
        t_csel csel;
        t_xsel xsel;
        t_aop  aop;
        t_src  src;
        t_wb   wb;
        t_jmp  jmp;
        t_step tgt;
        logic  last;
    } t_uword;

    function automatic t_uword uc(input t_csel csel, input t_xsel xsel, input t_aop aop,
                                  input t_src src, input t_wb wb, input t_jmp jmp,
                                  input t_step tgt, input logic last);
        t_uword w;
        w.csel = csel;
        w.xsel = xsel;
        w.aop  = aop;
        w.src  = src;
        w.wb   = wb;
        w.jmp  = jmp;
        w.tgt  = tgt;
        w.last = last;
        return w;
    endfunction

    // Control store: multiply issue, accumulate of the previous product, writeback
    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        unique case (step)
            // P = k * (b*r - y<<F) >>> F
            5'd0:  w = uc(C_B,  X_REF,  A_NOP,    S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd1:  w = uc(C_K,  X_NONE, A_LOAD,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd2:  w = uc(C_K,  X_NONE, A_SUBYF,  S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd3:  w = uc(C_K,  X_ALO,  A_NOP,    S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd4:  w = uc(C_K,  X_AHI,  A_LOAD,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            // D = ad*D >>> F - bd*(y - prev)
            5'd5:  w = uc(C_AD, X_DLO,  A_ADDH,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd6:  w = uc(C_AD, X_DHI,  A_LOAD,   S_P,   W_P,     J_NONE, '0, 1'b0);
            5'd7:  w = uc(C_BD, X_DY,   A_ADDH,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd8:  w = uc(C_BD, X_NONE, A_ASRSUB, S_P,   W_NONE,  J_NONE, '0, 1'b0);
            // v = P + I + D
            5'd9:  w = uc(C_BD, X_NONE, A_LOADX,  S_P,   W_D,     J_NONE, '0, 1'b0);
            5'd10: w = uc(C_BD, X_NONE, A_ADDX,   S_INT, W_NONE,  J_NONE, '0, 1'b0);
            5'd11: w = uc(C_BD, X_NONE, A_ADDX,   S_D,   W_NONE,  J_NONE, '0, 1'b0);
            5'd12: w = uc(C_BD, X_NONE, A_NOP,    S_P,   W_V,     J_NONE, '0, 1'b0);
            5'd13: w = uc(C_BD, X_NONE, A_NOP,    S_P,   W_CLAMP, J_NONE, '0, 1'b0);
            // tracking term ar*(v - applied), skipped when it is zero
            5'd14: w = uc(C_BI, X_EY,   A_TRK,    S_P,   W_NONE,  J_NOTRACK, UC_NOTRACK,
                          1'b0);
            5'd15: w = uc(C_AR, X_ALO,  A_NOP,    S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd16: w = uc(C_AR, X_AHI,  A_LOAD,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd17: w = uc(C_BI, X_EY,   A_ADDH,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd18: w = uc(C_BI, X_NONE, A_ASRADD, S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd19: w = uc(C_BI, X_NONE, A_ADDX,   S_INT, W_NONE,  J_ALWAYS, UC_INT_WB, 1'b0);
            // integral update without tracking
            5'd20: w = uc(C_BI, X_NONE, A_LOAD,   S_P,   W_NONE,  J_NONE, '0, 1'b0);
            5'd21: w = uc(C_BI, X_NONE, A_ADDX,   S_INT, W_NONE,  J_NONE, '0, 1'b0);
            5'd22: w = uc(C_BI, X_NONE, A_NOP,    S_P,   W_INT,   J_NONE, '0, 1'b1);
            default: w = uc(C_K, X_NONE, A_NOP,   S_P,   W_NONE,  J_NONE, '0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/pidaw_if.sv =====
`default_nettype none

// Sample channel: one beat per controller step
interface pidaw_in_if #(
    parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] reference;
    logic signed [SAMPLE_WIDTH-1:0] measurement;
    logic                           use_external;
    logic signed [SAMPLE_WIDTH-1:0] actuator_value;
    logic                           restart;

    modport source (
        output valid, reference, measurement, use_external, actuator_value, restart,
        input  ready
    );
    modport sink (
        input  valid, reference, measurement, use_external, actuator_value, restart,
        output ready
    );
endinterface

// Result channel: one beat per controller step
interface pidaw_out_if #(
    parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] drive;
    logic                           clamped;

    modport source (
        output valid, drive, clamped,
        input  ready
    );
    modport sink (
        input  valid, drive, clamped,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pid_controller_antiwindup_unit.sv =====
// Channel   Dir  Beat contents
// i_smp     in   reference, measurement, use_external, actuator_value, restart
// o_res     out  drive, clamped
// i_cfg_*   in   register index and data, one write per cycle with i_cfg_we
//
// A sample beat starts a microcode program on one shared 17-bit by N-bit multiplier
// and one wide accumulator: 21 steps, or 18 when the tracking term is zero
// (internal tracking and no clamp).
// i_smp.ready is low while the program runs; the result sits in an output register,
// and the program holds at its clamp step only while that register is still full.
// Reset (synchronous, active low) clears the state, the sequencer and the registers.
`default_nettype none

`include "pid_controller_antiwindup_unit_macros.svh"

module pid_controller_antiwindup_unit #(
    parameter int FRAC_BITS    = pidaw_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pidaw_in_if.sink                             i_smp,
    pidaw_out_if.source                          o_res,
    input  logic                                 i_cfg_we,
    input  logic [pidaw_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pidaw_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int IW    = pidaw_pkg::INT_W;
    localparam int CW    = pidaw_pkg::CHUNK_W;
    localparam int MAW   = pidaw_pkg::MUL_A_W;
    localparam int OPW   = (SW + 18 > IW + 2) ? SW + 18 : IW + 2;
    localparam int MB0   = (CW + 1 > OPW - CW) ? CW + 1 : OPW - CW;
    localparam int MBW   = (MB0 > SW + 2) ? MB0 : SW + 2;
    localparam int PRW   = MAW + MBW;
    localparam int AW    = OPW + 18;
    localparam int LW    = (SW > pidaw_pkg::LIMIT_W) ? SW : pidaw_pkg::LIMIT_W;
    localparam logic [LW-1:0] SMAX = LW'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [IW+1:0] HALF = (IW+2)'(64'd1 << (F - 1));

    // Configuration registers
    logic signed [pidaw_pkg::COEF_W-1:0]  r_k, r_b, r_bd, r_bi, r_ar;
    logic        [pidaw_pkg::LIMIT_W-1:0] r_lim;
    logic        [pidaw_pkg::POLE_W-1:0]  r_ad;

    // Sample latch and controller state
    logic signed [SW-1:0] r_ref, r_meas, r_act, r_prev;
    logic                 r_ext;
    logic signed [IW-1:0] r_int, r_dacc, r_p, r_v, r_vsat;

    // Datapath
    logic signed [PRW-1:0] r_prod;
    logic signed [AW-1:0]  r_acc, n_acc;

    // Sequencer and result
    logic                   r_busy;
    pidaw_pkg::t_step       r_step, n_step;
    logic                   r_out_valid;
    logic signed [SW-1:0]   r_drive;
    logic                   r_clamped;

    pidaw_pkg::t_uword      uw;
    logic                   adv;
    logic                   accept;
    logic                   out_load;

    assign uw       = pidaw_pkg::uc_rom(r_step);
    assign accept   = i_smp.valid && !r_busy;
    assign out_load = r_busy && (uw.wb == pidaw_pkg::W_CLAMP) && adv;
    // hold at the clamp step while the previous result is still waiting
    assign adv      = r_busy && !((uw.wb == pidaw_pkg::W_CLAMP) && r_out_valid && !o_res.ready);

    assign i_smp.ready   = !r_busy;
    assign o_res.valid   = r_out_valid;
    assign o_res.drive   = r_drive;
    assign o_res.clamped = r_clamped;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= pidaw_pkg::RST_GAIN_K;
            r_b   <= pidaw_pkg::RST_SP_WEIGHT;
            r_lim <= pidaw_pkg::RST_OUT_LIMIT;
            r_ad  <= pidaw_pkg::RST_DERIV_POLE;
            r_bd  <= pidaw_pkg::RST_COEF_ZERO;
            r_bi  <= pidaw_pkg::RST_COEF_ZERO;
            r_ar  <= pidaw_pkg::RST_COEF_ZERO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidaw_pkg::REG_GAIN_K:     r_k   <= i_cfg_data;
                pidaw_pkg::REG_SP_WEIGHT:  r_b   <= i_cfg_data;
                pidaw_pkg::REG_OUT_LIMIT:  r_lim <= i_cfg_data[pidaw_pkg::LIMIT_W-1:0];
                pidaw_pkg::REG_DERIV_POLE: r_ad  <= i_cfg_data[pidaw_pkg::POLE_W-1:0];
                pidaw_pkg::REG_DERIV_GAIN: r_bd  <= i_cfg_data;
                pidaw_pkg::REG_INTEG_GAIN: r_bi  <= i_cfg_data;
                pidaw_pkg::REG_TRACK_GAIN: r_ar  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiplier operands
    logic signed [MAW-1:0] m_a;
    logic signed [MBW-1:0] m_b;
    logic signed [PRW-1:0] prod_c;
    logic signed [SW:0]    dy, ey;

    assign dy = (SW+1)'(r_meas) - (SW+1)'(r_prev);
    assign ey = (SW+1)'(r_ref) - (SW+1)'(r_meas);

    always_comb begin
        unique case (uw.csel)
            pidaw_pkg::C_K:  m_a = MAW'(r_k);
            pidaw_pkg::C_B:  m_a = MAW'(r_b);
            pidaw_pkg::C_AD: m_a = MAW'({1'b0, r_ad});
            pidaw_pkg::C_BD: m_a = MAW'(r_bd);
            pidaw_pkg::C_BI: m_a = MAW'(r_bi);
            pidaw_pkg::C_AR: m_a = MAW'(r_ar);
            default:         m_a = '0;
        endcase
        unique case (uw.xsel)
            pidaw_pkg::X_REF: m_b = MBW'(r_ref);
            pidaw_pkg::X_DY:  m_b = MBW'(dy);
            pidaw_pkg::X_EY:  m_b = MBW'(ey);
            pidaw_pkg::X_ALO: m_b = MBW'({1'b0, r_acc[CW-1:0]});
            pidaw_pkg::X_AHI: m_b = MBW'($signed(r_acc[OPW-1:CW]));
            pidaw_pkg::X_DLO: m_b = MBW'({1'b0, r_dacc[CW-1:0]});
            pidaw_pkg::X_DHI: m_b = MBW'($signed(r_dacc[IW-1:CW]));
            default:          m_b = '0;
        endcase
    end

    assign prod_c = m_a * m_b;

    // Saturation of the accumulator, plain and shifted down by F
    logic signed [AW-1:0] acc_sh;
    logic [IW-1:0]        acc_sat, sh_sat;
    logic                 acc_fit, sh_fit;

    assign acc_sh  = r_acc >>> F;
    assign acc_fit = (&r_acc[AW-1:IW-1]) || !(|r_acc[AW-1:IW-1]);
    assign sh_fit  = (&acc_sh[AW-1:IW-1]) || !(|acc_sh[AW-1:IW-1]);
    assign acc_sat = acc_fit ? r_acc[IW-1:0]
                   : (r_acc[AW-1] ? pidaw_pkg::INT_MIN : pidaw_pkg::INT_MAX);
    assign sh_sat  = sh_fit ? acc_sh[IW-1:0]
                   : (acc_sh[AW-1] ? pidaw_pkg::INT_MIN : pidaw_pkg::INT_MAX);

    // Accumulator next value
    logic signed [AW-1:0] prod_x, src_x, applied_x;

    assign prod_x    = AW'(r_prod);
    assign applied_x = r_ext ? (AW'(r_act) <<< F) : AW'(r_vsat);

    always_comb begin
        unique case (uw.src)
            pidaw_pkg::S_P:   src_x = AW'(r_p);
            pidaw_pkg::S_INT: src_x = AW'(r_int);
            pidaw_pkg::S_D:   src_x = AW'(r_dacc);
            default:          src_x = '0;
        endcase
        unique case (uw.aop)
            pidaw_pkg::A_LOAD:   n_acc = prod_x;
            pidaw_pkg::A_ADDH:   n_acc = r_acc + (prod_x <<< CW);
            pidaw_pkg::A_SUBYF:  n_acc = r_acc - (AW'(r_meas) <<< F);
            pidaw_pkg::A_ASRSUB: n_acc = acc_sh - prod_x;
            pidaw_pkg::A_ASRADD: n_acc = acc_sh + prod_x;
            pidaw_pkg::A_LOADX:  n_acc = src_x;
            pidaw_pkg::A_ADDX:   n_acc = r_acc + src_x;
            pidaw_pkg::A_TRK:    n_acc = AW'(r_v) - applied_x;
            default:             n_acc = r_acc;
        endcase
    end

    // Output clamp and rounding
    logic [LW-1:0]           lim_w;
    logic signed [IW:0]      lim_q, v_w, vsat_c;
    logic signed [IW+1:0]    lim_d, rnd;
    logic                    clamp_c;
    logic signed [SW-1:0]    drive_c;

    assign lim_w = (LW'(r_lim) > SMAX) ? SMAX : LW'(r_lim);
    assign lim_q = $signed((IW+1)'(lim_w) << F);
    assign lim_d = $signed((IW+2)'(lim_w));
    assign v_w   = (IW+1)'(r_v);

    always_comb begin
        priority if (v_w > lim_q) begin
            vsat_c  = lim_q;
            clamp_c = 1'b1;
        end else if (v_w < -lim_q) begin
            vsat_c  = -lim_q;
            clamp_c = 1'b1;
        end else begin
            vsat_c  = v_w;
            clamp_c = 1'b0;
        end
        rnd     = ((IW+2)'(vsat_c) + HALF) >>> F;
        drive_c = (rnd > lim_d) ? SW'(lim_d) : SW'(rnd);
    end

    // Step counter with conditional jumps
    always_comb begin
        priority if (uw.last) begin
            n_step = '0;
        end else if ((uw.jmp == pidaw_pkg::J_ALWAYS)
                     || ((uw.jmp == pidaw_pkg::J_NOTRACK) && !r_ext && !r_clamped)) begin
            n_step = uw.tgt;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // Sequencer control and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (adv) begin
                r_step <= n_step;
                if (uw.last) begin
                    r_busy <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Controller state: cleared by reset and by a restart beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_dacc <= '0;
            r_prev <= '0;
        end else if (accept && i_smp.restart) begin
            r_int  <= '0;
            r_dacc <= '0;
            r_prev <= '0;
        end else if (adv) begin
            if (uw.wb == pidaw_pkg::W_D) begin
                r_dacc <= acc_sat;
            end
            if (uw.wb == pidaw_pkg::W_INT) begin
                r_int  <= acc_sat;
                r_prev <= r_meas;
            end
        end
    end

    // Sample latch and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ref  <= i_smp.reference;
            r_meas <= i_smp.measurement;
            r_act  <= i_smp.actuator_value;
            r_ext  <= i_smp.use_external;
        end
        if (adv) begin
            if (uw.xsel != pidaw_pkg::X_NONE) begin
                r_prod <= prod_c;
            end
            r_acc <= n_acc;
            if (uw.wb == pidaw_pkg::W_P) begin
                r_p <= sh_sat;
            end
            if (uw.wb == pidaw_pkg::W_V) begin
                r_v <= acc_sat;
            end
            if (uw.wb == pidaw_pkg::W_CLAMP) begin
                r_vsat    <= IW'(vsat_c);
                r_drive   <= drive_c;
                r_clamped <= clamp_c;
            end
        end
    end

    // Checks
    `PIDAW_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        i_smp.valid && i_smp.ready, r_busy && (r_step == '0),
        "accepted beat did not start the program")
    `PIDAW_ASSERT_IMP(a_step_range, i_clk, i_rst_n,
        r_busy, r_step <= pidaw_pkg::UC_LAST,
        "step counter left the program")
    `PIDAW_ASSERT_IMP(a_drive_in_limit, i_clk, i_rst_n,
        r_out_valid, ((IW+2)'(r_drive) <= lim_d) && ((IW+2)'(r_drive) >= -lim_d),
        "drive outside the output limit")
    `PIDAW_ASSERT_IMP(a_result_from_program, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_busy),
        "result appeared without a running program")

endmodule

`default_nettype wire

// ===== tb/sv/pid_controller_antiwindup_unit_tb.sv =====
`timescale 1ns / 100ps

module pid_controller_antiwindup_unit_tb;

    localparam int SW      = pidaw_pkg::SAMPLE_WIDTH_DEF;
    localparam int FRAC    = pidaw_pkg::FRAC_BITS_DEF;
    localparam int COEF_W  = pidaw_pkg::COEF_W;
    localparam int LIMIT_W = pidaw_pkg::LIMIT_W;
    localparam int POLE_W  = pidaw_pkg::POLE_W;
    localparam int CFG_W   = pidaw_pkg::CFG_W;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 40;      // program tail after the result beat
    localparam int MAX_IDLE        = 19;
    localparam int HOLD_AFTER      = 400;     // results before the long back-pressure
    localparam int HOLD_CYCLES     = 300;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int TIMEOUT_NS      = 10_000_000;

    localparam longint Q_ONE  = longint'(1) <<< FRAC;
    localparam longint Q_HALF = longint'(1) <<< (FRAC - 1);
    localparam longint Q_MAX  = 64'sd2147483647;
    localparam longint Q_MIN  = -64'sd2147483648;
    localparam longint S_MAX  = (longint'(1) <<< (SW - 1)) - 1;

    typedef pidaw_pkg::t_reg_idx t_idx;
    typedef logic [2:0] t_set;

    // index with no register behind it
    localparam t_idx REG_SPARE = 3'd7;

    // register sets used by the directed part
    localparam t_set SET_RESET    = 3'd0;
    localparam t_set SET_UNITY    = 3'd1;
    localparam t_set SET_ZERO_LIM = 3'd2;
    localparam t_set SET_EXTREME  = 3'd3;
    localparam t_set SET_PI       = 3'd4;
    localparam int   N_DIRECTED   = 24;

    typedef struct packed {
        logic signed [SW-1:0] reference;
        logic signed [SW-1:0] measurement;
        logic                 use_external;
        logic signed [SW-1:0] actuator_value;
        logic                 restart;
    } t_pid_sample;

    typedef struct packed {
        logic signed [SW-1:0] drive;
        logic                 clamped;
    } t_pid_result;

    typedef struct packed {
        logic signed [COEF_W-1:0]  gain_k;
        logic signed [COEF_W-1:0]  sp_weight;
        logic        [LIMIT_W-1:0] out_limit;
        logic        [POLE_W-1:0]  deriv_pole;
        logic signed [COEF_W-1:0]  deriv_gain;
        logic signed [COEF_W-1:0]  integ_gain;
        logic signed [COEF_W-1:0]  track_gain;
    } t_ctl_regs;

    // raw write data, element i goes to register index i
    typedef logic [0:6][CFG_W-1:0] t_reg_words;

    typedef struct packed {
        t_set                 gset;
        logic signed [SW-1:0] reference;
        logic signed [SW-1:0] measurement;
        logic                 use_external;
        logic signed [SW-1:0] actuator_value;
        logic                 restart;
        logic                 golden;
        logic signed [SW-1:0] want_drive;
        logic                 want_clamped;
    } t_dir_row;

    localparam t_reg_words GAIN_SETS [0:4] = '{
        {16'd0,    16'd4096, 16'h7FFF, 16'd0,    16'd0,    16'd0,    16'd0},
        {16'd4096, 16'd4096, 16'h7FFF, 16'd0,    16'd0,    16'd0,    16'd0},
        {16'd4096, 16'd4096, 16'h8000, 16'd0,    16'd0,    16'd0,    16'd0},
        {16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000},
        {16'd8192, 16'd2048, 16'd1000, 16'd3000, 16'd2000, 16'd300,  16'd500}
    };

    // set, ref, meas, ext, actuator, restart, golden, drive, clamped
    localparam t_dir_row DIRECTED [0:N_DIRECTED-1] = '{
        // all gains zero out of reset
        '{SET_RESET, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0, 1'b1, 16'sd0, 1'b0},
        '{SET_RESET, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 1'b1, 16'sd0, 1'b0},
        // unity gain passes the error, clamped at full scale
        '{SET_UNITY, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
        '{SET_UNITY, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0, 1'b1, -16'sd32767, 1'b1},
        '{SET_UNITY, 16'sd5, 16'sd3, 1'b1, 16'sd1234, 1'b0, 1'b1, 16'sd2, 1'b0},
        '{SET_UNITY, -16'sd7, 16'sd0, 1'b0, 16'sd0, 1'b1, 1'b1, -16'sd7, 1'b0},
        // zero limit: any nonzero sum clamps to zero
        '{SET_ZERO_LIM, 16'sd1, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b1, 16'sd0, 1'b1},
        '{SET_ZERO_LIM, 16'sd100, 16'sd100, 1'b0, 16'sd0, 1'b0, 1'b1, 16'sd0, 1'b0},
        '{SET_ZERO_LIM, -16'sd1, 16'sd0, 1'b1, 16'sh7FFF, 1'b0, 1'b1, 16'sd0, 1'b1},
        // extreme coefficients, saturation everywhere
        '{SET_EXTREME, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_EXTREME, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_EXTREME, 16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_EXTREME, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_EXTREME, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{SET_EXTREME, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh8000, 1'b0, 1'b0, 16'sd0, 1'b0},
        // PI with tracking: wind up, track inside and outside, restart
        '{SET_PI, 16'sd2000, 16'sd0, 1'b0, 16'sd0, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, 16'sd2000, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, 16'sd2000, 16'sd100, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, 16'sd2000, 16'sd500, 1'b1, 16'sd800, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, 16'sd2000, 16'sd1500, 1'b1, -16'sd1000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, 16'sd0, 16'sd1900, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, 16'sd0, 16'sd2100, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, -16'sd3000, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SET_PI, -16'sd3000, -16'sd3000, 1'b0, 16'sd0, 1'b1, 1'b0, 16'sd0, 1'b0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    t_idx               cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    pidaw_in_if  smp_if ();
    pidaw_out_if res_if ();

    pid_controller_antiwindup_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // controller mirror: registers and loop state
    t_ctl_regs   ctl_regs;
    longint      integ_state;
    longint      deriv_state;
    longint      prev_meas;

    t_pid_result pending_drives [$];

    bit src_idle;
    bit snk_idle;
    bit draining;
    bit hold_done;
    int last_drive;
    int mismatches;
    int samples_sent;
    int restarts_sent;
    int results_seen;
    int clamped_seen;
    int loads_done;

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic longint clip32(input longint x);
        if (x > Q_MAX) return Q_MAX;
        if (x < Q_MIN) return Q_MIN;
        return x;
    endfunction

    function automatic void mirror_reg_write(input t_idx idx, input logic [CFG_W-1:0] data);
        case (idx)
            pidaw_pkg::REG_GAIN_K:     ctl_regs.gain_k     = data;
            pidaw_pkg::REG_SP_WEIGHT:  ctl_regs.sp_weight  = data;
            pidaw_pkg::REG_OUT_LIMIT:  ctl_regs.out_limit  = data[LIMIT_W-1:0];
            pidaw_pkg::REG_DERIV_POLE: ctl_regs.deriv_pole = data[POLE_W-1:0];
            pidaw_pkg::REG_DERIV_GAIN: ctl_regs.deriv_gain = data;
            pidaw_pkg::REG_INTEG_GAIN: ctl_regs.integ_gain = data;
            pidaw_pkg::REG_TRACK_GAIN: ctl_regs.track_gain = data;
            default: ;
        endcase
    endfunction

    // One controller step: drive for this sample, then advance the loop state
    function automatic t_pid_result pid_predict(input t_pid_sample s);
        t_pid_result o;
        longint r, y, ua, k, b, ad, bd, bi, ar, lim, lim_q;
        longint p, d, v, vsat, applied, drv, inc;
        r   = longint'(s.reference);
        y   = longint'(s.measurement);
        ua  = longint'(s.actuator_value);
        k   = longint'(ctl_regs.gain_k);
        b   = longint'(ctl_regs.sp_weight);
        ad  = longint'(ctl_regs.deriv_pole);
        bd  = longint'(ctl_regs.deriv_gain);
        bi  = longint'(ctl_regs.integ_gain);
        ar  = longint'(ctl_regs.track_gain);
        lim = longint'(ctl_regs.out_limit);
        if (lim > S_MAX) lim = S_MAX;
        lim_q = lim * Q_ONE;
        if (s.restart) begin
            integ_state = 0;
            deriv_state = 0;
            prev_meas   = 0;
        end
        p = clip32((k * (b * r - y * Q_ONE)) >>> FRAC);
        d = clip32(((ad * deriv_state) >>> FRAC) - bd * (y - prev_meas));
        v = clip32(p + integ_state + d);
        deriv_state = d;
        // clamp at full precision
        if (v > lim_q) begin
            vsat = lim_q;
            o.clamped = 1'b1;
        end else if (v < -lim_q) begin
            vsat = -lim_q;
            o.clamped = 1'b1;
        end else begin
            vsat = v;
            o.clamped = 1'b0;
        end
        drv = (vsat + Q_HALF) >>> FRAC;
        if (drv > lim) drv = lim;
        // integral with back-calculation against the applied actuator
        applied = s.use_external ? ua * Q_ONE : vsat;
        inc = bi * (r - y) + ((ar * (v - applied)) >>> FRAC);
        integ_state = clip32(integ_state + inc);
        prev_meas = y;
        o.drive = drv[SW-1:0];
        return o;
    endfunction

    function automatic logic [CFG_W-1:0] corner_word();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            default: return rnd[CFG_W-1:0];
        endcase
    endfunction

    // Tuning for one random phase: plausible controller or corner values
    function automatic t_reg_words draw_gains(input bit corners);
        t_reg_words w;
        int k;
        if (corners) begin
            for (int i = int'(pidaw_pkg::REG_GAIN_K); i <= int'(pidaw_pkg::REG_TRACK_GAIN);
                 i++) w[i] = corner_word();
        end else begin
            k = int'($urandom_range(1024, 16384));
            if ($urandom_range(0, 9) == 0) k = -k;
            w[pidaw_pkg::REG_GAIN_K]     = 16'(k);
            w[pidaw_pkg::REG_SP_WEIGHT]  = 16'($urandom_range(0, 4096));
            w[pidaw_pkg::REG_OUT_LIMIT]  = ($urandom_range(0, 3) == 0)
                                           ? 16'($urandom_range(0, 32767))
                                           : 16'($urandom_range(20, 3000));
            w[pidaw_pkg::REG_DERIV_POLE] = 16'($urandom_range(0, 4095));
            w[pidaw_pkg::REG_DERIV_GAIN] = 16'($urandom_range(0, 12000));
            w[pidaw_pkg::REG_INTEG_GAIN] = 16'($urandom_range(0, 800));
            w[pidaw_pkg::REG_TRACK_GAIN] = 16'($urandom_range(0, 4096));
        end
        return w;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    endtask

    // Wait out every outstanding result and the program tail
    task automatic drain_and_settle();
        draining = 1'b1;
        while (pending_drives.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        draining = 1'b0;
    endtask

    task automatic load_gains(input t_reg_words w);
        logic [31:0] junk;
        junk = $urandom;
        for (int i = int'(pidaw_pkg::REG_GAIN_K); i <= int'(pidaw_pkg::REG_TRACK_GAIN); i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= t_idx'(i);
            cfg_data <= w[i];
            @(posedge clk);
            mirror_reg_write(t_idx'(i), w[i]);
        end
        // the spare index must leave every register alone
        cfg_idx  <= REG_SPARE;
        cfg_data <= junk[CFG_W-1:0];
        @(posedge clk);
        mirror_reg_write(REG_SPARE, junk[CFG_W-1:0]);
        cfg_we <= 1'b0;
        loads_done++;
    endtask

    // Offer one sample beat; predict its result once accepted
    task automatic offer_sample(input t_pid_sample s, input bit has_golden,
                                input t_pid_result golden);
        int gap;
        t_pid_result predicted;
        gap = src_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.reference      <= s.reference;
        smp_if.measurement    <= s.measurement;
        smp_if.use_external   <= s.use_external;
        smp_if.actuator_value <= s.actuator_value;
        smp_if.restart        <= s.restart;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        predicted = pid_predict(s);
        pending_drives.push_back(has_golden ? golden : predicted);
        last_drive = int'(predicted.drive);
        samples_sent++;
        if (s.restart) restarts_sent++;
    endtask

    function automatic int clip_sample(input int x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // Closed loop against a first-order plant, with stray noise beats
    task automatic run_plant(input int n_items);
        t_pid_sample s;
        t_pid_result none;
        logic [31:0] rnd;
        int roll, plant_y, setp, act;
        plant_y = 0;
        setp    = 0;
        none    = '0;
        for (int n = 0; n < n_items; n++) begin
            roll = int'($urandom_range(0, 99));
            if (roll < 15) begin
                rnd = $urandom;
                s.reference   = rnd[SW-1:0];
                s.use_external = rnd[SW];
                s.restart     = (rnd[31:28] == 4'hF);
                rnd = $urandom;
                s.measurement = rnd[SW-1:0];
                s.actuator_value = rnd[31:32-SW];
            end else begin
                s.restart = (n == 0 || roll < 18);
                if (s.restart) begin
                    plant_y = int'($urandom_range(0, 4000)) - 2000;
                    setp    = int'($urandom_range(0, 8000)) - 4000;
                end else if (roll >= 95) begin
                    setp = int'($urandom_range(0, 8000)) - 4000;
                end
                plant_y = clip_sample(plant_y + (last_drive - plant_y) / 4
                                      + int'($urandom_range(0, 40)) - 20);
                s.reference    = 16'(setp);
                s.measurement  = 16'(plant_y);
                s.use_external = ($urandom_range(0, 3) == 0);
                act = clip_sample(last_drive + int'($urandom_range(0, 200)) - 100);
                if ($urandom_range(0, 4) == 0) begin
                    rnd = $urandom;
                    s.actuator_value = rnd[SW-1:0];
                end else begin
                    s.actuator_value = 16'(act);
                end
            end
            offer_sample(s, 1'b0, none);
        end
    endtask

    // Result side: random stalls, one long hold-off, compare each beat
    initial begin : result_sink
        int gap;
        t_pid_result want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER && !draining) begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = snk_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            results_seen++;
            if (res_if.clamped) clamped_seen++;
            if (pending_drives.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat drive=%0d clamped=%0b",
                                        res_if.drive, res_if.clamped));
            end else begin
                want = pending_drives.pop_front();
                if (res_if.drive !== want.drive)
                    flag_mismatch($sformatf("drive %0d, expected %0d",
                                            res_if.drive, want.drive));
                if (res_if.clamped !== want.clamped)
                    flag_mismatch($sformatf("clamped %0b, expected %0b",
                                            res_if.clamped, want.clamped));
            end
        end
    end

    initial begin : stimulus
        t_pid_sample s;
        t_pid_result gold;
        t_set cur_set;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = pidaw_pkg::REG_GAIN_K;
        cfg_data              = '0;
        smp_if.valid          = 1'b0;
        smp_if.reference      = '0;
        smp_if.measurement    = '0;
        smp_if.use_external   = 1'b0;
        smp_if.actuator_value = '0;
        smp_if.restart        = 1'b0;
        res_if.ready          = 1'b0;
        ctl_regs.gain_k       = pidaw_pkg::RST_GAIN_K;
        ctl_regs.sp_weight    = pidaw_pkg::RST_SP_WEIGHT;
        ctl_regs.out_limit    = pidaw_pkg::RST_OUT_LIMIT;
        ctl_regs.deriv_pole   = pidaw_pkg::RST_DERIV_POLE;
        ctl_regs.deriv_gain   = pidaw_pkg::RST_COEF_ZERO;
        ctl_regs.integ_gain   = pidaw_pkg::RST_COEF_ZERO;
        ctl_regs.track_gain   = pidaw_pkg::RST_COEF_ZERO;
        integ_state = 0;
        deriv_state = 0;
        prev_meas   = 0;
        src_idle    = 1'b1;
        snk_idle    = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reloading registers whenever the set changes
        cur_set = SET_RESET;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].gset != cur_set) begin
                smp_if.valid <= 1'b0;
                drain_and_settle();
                cur_set = DIRECTED[i].gset;
                load_gains(GAIN_SETS[cur_set]);
            end
            s.reference      = DIRECTED[i].reference;
            s.measurement    = DIRECTED[i].measurement;
            s.use_external   = DIRECTED[i].use_external;
            s.actuator_value = DIRECTED[i].actuator_value;
            s.restart        = DIRECTED[i].restart;
            gold.drive       = DIRECTED[i].want_drive;
            gold.clamped     = DIRECTED[i].want_clamped;
            offer_sample(s, DIRECTED[i].golden, gold);
        end

        // random phases: new tuning and a new idle pattern each time
        for (int ph = 0; ph < N_PHASES; ph++) begin
            smp_if.valid <= 1'b0;
            drain_and_settle();
            load_gains(draw_gains(ph % 3 == 1));
            src_idle = (ph % 4 == 0) || (ph % 4 == 2);
            snk_idle = (ph % 4 == 0) || (ph % 4 == 3);
            run_plant(ITEMS_PER_PHASE);
        end

        smp_if.valid <= 1'b0;
        drain_and_settle();
        $display("Covered %0d samples (%0d restarts) across %0d register loads.",
                 samples_sent, restarts_sent, loads_done);
        $display("Checked %0d results, %0d clamped; %0d mismatches.",
                 results_seen, clamped_seen, mismatches);
        if (mismatches == 0 && pending_drives.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop if a handshake never completes
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding.", pending_drives.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pidaw_pkg.sv
src/pidaw_if.sv
src/pid_controller_antiwindup_unit.sv
tb/sv/pid_controller_antiwindup_unit_tb.sv
